// File: rtl/assert_macros.svh
// Assertion macros used by the ring buffer producer controller (crbp_ctrl).
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: invariant violated");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/crbp_pkg.sv
// Types, widths and codes for the credit ring buffer producer.
// No dependencies; imported by every module of the block.
package crbp_pkg;

  localparam int unsigned FIFO_W    = 21;
  localparam int unsigned ALIGN_W   = 4;
  localparam int unsigned PAGE_W    = 21;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned OFFS_W    = 20;
  localparam int unsigned NEED_W    = CNT_W + PAGE_W;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned DVD_W     = 22;
  localparam int unsigned DSR_W     = 21;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 21;

  localparam int unsigned MAX_FIFO_BYTES_DEF   = 1048576;
  localparam logic [FIFO_W-1:0]  FIFO_RESET    = 21'd65536;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET   = 4'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_FIFO_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 1'd1;

  typedef enum logic [1:0] {
    KIND_SET_PAGE,
    KIND_RESERVE,
    KIND_PUSH,
    KIND_ACK
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_UNSET,
    ERR_MISALIGN,
    ERR_TOO_LARGE,
    ERR_OVERSIZE
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_A,
    ST_DIV_B,
    ST_FIXUP,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [PAGE_W-1:0]   page_bytes;
    logic [CNT_W-1:0]    page_count;
    logic [TOTAL_W-1:0]  acked_total;
  } in_t;

  typedef struct packed {
    logic [2:0]          error_code;
    logic                space_ok;
    logic [FIFO_W-1:0]   free_bytes;
    logic [OFFS_W-1:0]   write_offset;
    logic [TOTAL_W-1:0]  sent_total;
    logic                drained;
  } out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_sel_b;
    logic latch_a;
    logic latch_b;
    logic fixup;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  set_err;
    logic  div_done;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/credit_ring_buffer_producer.sv
// Top level of the credit ring buffer producer.
// Depends on crbp_pkg, crbp_ctrl, crbp_dp (and crbp_div below it).
//
// Usage:
//   in_valid/in_ready carry one request (in_data: kind, page_bytes,
//   page_count, acked_total); out_valid/out_ready carry exactly one result
//   per request (out_data), in request order.
//   cfg_we/cfg_index/cfg_wdata write fifo_bytes (index 0) and
//   alignment_log2 (index 1); write only while no request is in flight.
// Timing:
//   Reserve, push, acknowledge and rejected page-size requests: the result is
//   computed in the execute state and registered in the response state; the
//   next request is accepted in the cycle the result is loaded.
//   The count-times-page-size product is formed at acceptance.
//   An accepted page-size change runs two 22-step passes of the bit-serial
//   remainder unit (pointer round-up and ring alignment), then a fixup step.
// Reset: synchronous, active low; state clears, page size becomes unset,
//   fifo_bytes returns to 65536 and alignment_log2 to 6.
// Stall: a result waiting on out_ready holds; one further request may be
//   accepted and executed, then in_ready stays low until the result is taken.
module credit_ring_buffer_producer #(
  parameter int unsigned MAX_FIFO_BYTES = crbp_pkg::MAX_FIFO_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crbp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  crbp_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output crbp_pkg::out_t                 out_data
);
  import crbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  crbp_dp #(
    .MAX_FIFO_BYTES (MAX_FIFO_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

// File: rtl/crbp_div.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on crbp_pkg for operand widths.
module crbp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [crbp_pkg::DVD_W-1:0] dividend,
  input  logic [crbp_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [crbp_pkg::DSR_W-1:0] rem
);
  import crbp_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W);

  logic [DVD_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DVD_W-1:0] trial;
  logic             ge;

  assign trial   = {rem_r[DVD_W-2:0], dvd_r[DVD_W-1]};
  assign ge      = trial >= {1'b0, dsr_r};
  assign rem_nxt = ge ? (trial - {1'b0, dsr_r}) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r[DSR_W-1:0];

endmodule

// File: rtl/crbp_dp.sv
// Datapath: configuration, ring state, request arithmetic and result register.
// Depends on crbp_pkg and crbp_div.
module crbp_dp #(
  parameter int unsigned MAX_FIFO_BYTES = crbp_pkg::MAX_FIFO_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crbp_pkg::CFG_W-1:0]     cfg_wdata,
  input  crbp_pkg::in_t                  in_data,
  input  crbp_pkg::cmd_t                 cmd,
  output crbp_pkg::sts_t                 sts,
  output crbp_pkg::out_t                 out_data,
  output logic                           out_valid,
  input  logic                           out_ready
);
  import crbp_pkg::*;

  localparam int unsigned MAX_W = $clog2(MAX_FIFO_BYTES + 1);
  localparam int unsigned CMP_W = (MAX_W > FIFO_W) ? MAX_W : FIFO_W;

  // configuration
  logic [FIFO_W-1:0]  cfg_fifo_r;
  logic [ALIGN_W-1:0] cfg_align_r;

  // ring state
  logic [OFFS_W-1:0]  wo_r, wo_nxt;
  logic [TOTAL_W-1:0] sent_r, sent_nxt;
  logic [TOTAL_W-1:0] acked_r, acked_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [FIFO_W-1:0]  usable_r, usable_nxt;
  err_t               err_r, err_nxt;
  logic               space_ok_r, space_ok_nxt;

  // captured transaction
  kind_t              kind_r;
  logic [PAGE_W-1:0]  page_in_r;
  logic [TOTAL_W-1:0] acked_in_r;
  logic [NEED_W-1:0]  need_r;

  // page size change intermediates
  logic [DVD_W-1:0]   rounded_r;
  logic [FIFO_W-1:0]  aligned_r;

  out_t               out_data_r;
  logic               out_valid_r, out_valid_nxt;

  logic [CMP_W-1:0]   fifo_cmp;
  logic [FIFO_W-1:0]  fifo_eff;
  logic [TOTAL_W-1:0] outstanding;
  logic [FIFO_W-1:0]  free_cur;
  logic [MASK_W-1:0]  amask;
  err_t               set_err;
  logic [DVD_W-1:0]   dvd_a;
  logic [DVD_W-1:0]   div_dvd;
  logic               div_done;
  logic [DSR_W-1:0]   div_rem;
  logic [DVD_W-1:0]   push_sum;
  logic               push_wrap;
  logic [TOTAL_W-1:0] pad;

  assign fifo_cmp = CMP_W'(cfg_fifo_r);
  assign fifo_eff = (fifo_cmp > CMP_W'(MAX_FIFO_BYTES)) ? FIFO_W'(MAX_FIFO_BYTES) : cfg_fifo_r;

  // free space saturates at zero when more is outstanding than the ring holds
  assign outstanding = sent_r - acked_r;
  assign free_cur    = (outstanding > TOTAL_W'(fifo_eff)) ? '0
                                                          : (fifo_eff - outstanding[FIFO_W-1:0]);

  assign amask = (MASK_W'(1) << cfg_align_r) - MASK_W'(1);

  always_comb begin
    if (page_in_r == '0) begin
      set_err = ERR_UNSET;
    end else if ((page_in_r[MASK_W-1:0] & amask) != '0) begin
      set_err = ERR_MISALIGN;
    end else if (page_in_r > fifo_eff) begin
      set_err = ERR_TOO_LARGE;
    end else begin
      set_err = ERR_OK;
    end
  end

  assign dvd_a   = DVD_W'(wo_r) + DVD_W'(page_in_r) - DVD_W'(1);
  assign div_dvd = cmd.div_sel_b ? DVD_W'(fifo_eff) : dvd_a;

  crbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (page_in_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign push_sum  = DVD_W'(wo_r) + DVD_W'(need_r[FIFO_W-1:0]);
  assign push_wrap = push_sum >= DVD_W'(usable_r);
  // tail padding is modulo 2^32 when the ring shrank after the page size was set
  assign pad       = TOTAL_W'(fifo_eff) - TOTAL_W'(usable_r);

  always_comb begin
    wo_nxt       = wo_r;
    sent_nxt     = sent_r;
    acked_nxt    = acked_r;
    page_nxt     = page_r;
    usable_nxt   = usable_r;
    err_nxt      = err_r;
    space_ok_nxt = space_ok_r;
    if (cmd.exec) begin
      err_nxt      = ERR_OK;
      space_ok_nxt = 1'b0;
      case (kind_r)
        KIND_SET_PAGE: begin
          err_nxt = set_err;
        end
        KIND_RESERVE: begin
          if (page_r == '0) begin
            err_nxt = ERR_UNSET;
          end else if (need_r > NEED_W'(fifo_eff)) begin
            err_nxt = ERR_OVERSIZE;
          end else begin
            space_ok_nxt = NEED_W'(free_cur) >= need_r;
          end
        end
        KIND_PUSH: begin
          if (page_r == '0) begin
            err_nxt = ERR_UNSET;
          end else if (need_r > NEED_W'(usable_r)) begin
            err_nxt = ERR_OVERSIZE;
          end else if (push_wrap) begin
            wo_nxt   = OFFS_W'(push_sum - DVD_W'(usable_r));
            sent_nxt = sent_r + TOTAL_W'(need_r[FIFO_W-1:0]) + pad;
          end else begin
            wo_nxt   = push_sum[OFFS_W-1:0];
            sent_nxt = sent_r + TOTAL_W'(need_r[FIFO_W-1:0]);
          end
        end
        KIND_ACK: begin
          acked_nxt = acked_in_r;
        end
        default: begin
          err_nxt = err_r;
        end
      endcase
    end
    if (cmd.fixup) begin
      // past the last whole page: wrap to zero, credit skipped tail bytes
      if (rounded_r >= DVD_W'(aligned_r)) begin
        if (rounded_r <= DVD_W'(fifo_eff)) begin
          sent_nxt = sent_r + TOTAL_W'(DVD_W'(fifo_eff) - rounded_r);
        end
        wo_nxt = '0;
      end else begin
        wo_nxt = rounded_r[OFFS_W-1:0];
      end
      page_nxt   = page_in_r;
      usable_nxt = aligned_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fifo_r  <= FIFO_RESET;
      cfg_align_r <= ALIGN_RESET;
      wo_r        <= '0;
      sent_r      <= '0;
      acked_r     <= '0;
      page_r      <= '0;
      usable_r    <= '0;
      err_r       <= ERR_OK;
      space_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIFO_BYTES: cfg_fifo_r  <= cfg_wdata[FIFO_W-1:0];
          CFG_ALIGN_LOG2: cfg_align_r <= cfg_wdata[ALIGN_W-1:0];
          default:        cfg_fifo_r  <= cfg_fifo_r;
        endcase
      end
      wo_r        <= wo_nxt;
      sent_r      <= sent_nxt;
      acked_r     <= acked_nxt;
      page_r      <= page_nxt;
      usable_r    <= usable_nxt;
      err_r       <= err_nxt;
      space_ok_r  <= space_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_data.kind;
      page_in_r  <= in_data.page_bytes;
      acked_in_r <= in_data.acked_total;
      need_r     <= NEED_W'(in_data.page_count) * NEED_W'(page_r);
    end
    if (cmd.latch_a) begin
      rounded_r <= dvd_a - DVD_W'(div_rem);
    end
    if (cmd.latch_b) begin
      aligned_r <= fifo_eff - div_rem;
    end
    if (cmd.resp_load) begin
      out_data_r.error_code   <= err_r;
      out_data_r.space_ok     <= space_ok_r;
      out_data_r.free_bytes   <= free_cur;
      out_data_r.write_offset <= wo_r;
      out_data_r.sent_total   <= sent_r;
      out_data_r.drained      <= (sent_r == acked_r);
    end
  end

  assign sts.kind     = kind_r;
  assign sts.set_err  = (set_err != ERR_OK);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/crbp_ctrl.sv
// Controller state machine sequencing capture, execute, divide, fixup and response.
// Depends on crbp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output crbp_pkg::cmd_t cmd,
  input  crbp_pkg::sts_t sts
);
  import crbp_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.kind == KIND_SET_PAGE && !sts.set_err) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_A;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_DIV_A: begin
        // take the round-up remainder, start the ring-size remainder
        if (sts.div_done) begin
          cmd.latch_a   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_b = 1'b1;
          state_nxt     = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (sts.div_done) begin
          cmd.latch_b = 1'b1;
          state_nxt   = ST_FIXUP;
        end
      end
      ST_FIXUP: begin
        cmd.fixup = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // once the output is free, load the result and take the next transaction in the same cycle
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          in_ready      = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_capture_exec, clk, rst_n, in_valid && in_ready, state_r == ST_EXEC)
  `ASSERT_ALWAYS(a_div_done_state, clk, rst_n, !sts.div_done || state_r == ST_DIV_A || state_r == ST_DIV_B)
  `ASSERT_ALWAYS(a_resp_free, clk, rst_n, !cmd.resp_load || sts.out_free)

endmodule
